>>> hw/rtl/wavhp_pkg.sv
// ---------------------------------------------------------------------------
// WAV header parser package
// Shared types and constants: parse phases, magic words, status codes,
// the accepted input item and the packed result item.
// ---------------------------------------------------------------------------
`default_nettype none

package wavhp_pkg;

	// Parse phases
	localparam logic [3:0] PH_RIFF  = 4'd0;
	localparam logic [3:0] PH_RSIZE = 4'd1;
	localparam logic [3:0] PH_WAVE  = 4'd2;
	localparam logic [3:0] PH_ID    = 4'd3;
	localparam logic [3:0] PH_FSIZE = 4'd4;
	localparam logic [3:0] PH_FMT   = 4'd5;
	localparam logic [3:0] PH_USIZE = 4'd6;
	localparam logic [3:0] PH_SKIP  = 4'd7;
	localparam logic [3:0] PH_DSIZE = 4'd8;

	// Magic words as they sit in the little-endian shift word
	localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
	localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
	localparam logic [31:0] MAGIC_FMT  = 32'h2074_6D66;
	localparam logic [31:0] MAGIC_DATA = 32'h6174_6164;

	// Result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_RIFF  = 3'd1;
	localparam logic [2:0] ST_BAD_WAVE  = 3'd2;
	localparam logic [2:0] ST_NO_DATA   = 3'd3;
	localparam logic [2:0] ST_BAD_DEPTH = 3'd4;
	localparam logic [2:0] ST_BAD_CHAN  = 3'd5;

	// Supported sample depths and channel counts
	localparam logic [15:0] DEPTH_U8  = 16'd8;
	localparam logic [15:0] DEPTH_I16 = 16'd16;
	localparam logic [15:0] DEPTH_F32 = 16'd32;
	localparam logic [15:0] DEPTH_F64 = 16'd64;
	localparam logic [15:0] CHAN_MONO   = 16'd1;
	localparam logic [15:0] CHAN_STEREO = 16'd2;
	localparam logic [15:0] TAG_PCM     = 16'd1;

	localparam int IN_W  = 8;
	localparam int OUT_W = 168;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       final_byte;
	} in_item_t;

	// First field in the highest bits
	typedef struct packed {
		logic [31:0] payload_size;
		logic [15:0] sample_bits;
		logic [15:0] block_align;
		logic [31:0] byte_rate;
		logic [31:0] sample_rate;
		logic [15:0] channels;
		logic [15:0] format_tag;
		logic        not_pcm;
		logic [2:0]  format_code;
		logic [2:0]  status;
	} res_t;

endpackage

`default_nettype wire

>>> hw/rtl/wav_header_parser_core.sv
// ---------------------------------------------------------------------------
// WAV header parser core
// Parses a RIFF/WAVE byte stream and returns one header or error result
// per file.
// ---------------------------------------------------------------------------
//
// Channel   Dir   Transfer carries
// s_*       in    one file byte; tuser = first byte of file, tlast = last byte
// m_*       out   one result per parse: status, format code and header fields
//
// Cycles: one byte per clock while the output register is free or its result
// is being taken. A transfer lands in the input register, the parse step
// updates the state from it once the output side can proceed, and any result
// is held in the output register, so a new byte is taken while the last is parsed.
// Reset: arst_n clears phase, counters, captured fields and both valid flags.
// Stalls: while a result waits and m_tready is low, the parse step holds and
// s_tready drops once the input register is full.
//
`default_nettype none

module wav_header_parser_core (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [7:0]   s_tdata,   // [7:0] data_byte
	input  wire  [0:0]   s_tuser,   // [0] first_byte
	input  wire          s_tlast,   // final_byte
	output logic         m_tvalid,
	input  wire          m_tready,
	// [2:0] status, [5:3] format_code, [6] not_pcm, [22:7] format_tag,
	// [38:23] channels, [70:39] sample_rate, [102:71] byte_rate,
	// [118:103] block_align, [134:119] sample_bits, [166:135] payload_size,
	// [167] zero
	output logic [167:0] m_tdata
);
	import wavhp_pkg::*;

	in_item_t s_item;
	in_item_t item_s1;
	res_t     res;
	logic     proceed;
	logic     fire;
	logic     res_valid;

	// gather the incoming transfer into one item: data byte, first flag, last flag
	assign s_item = {s_tdata, s_tuser[0], s_tlast};

	wavhp_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.s_ready (s_tready),
		.s_item  (s_item),
		.proceed (proceed),
		.fire    (fire),
		.item_s1 (item_s1)
	);

	// advance the parse state once per registered byte
	wavhp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// hold the result until the downstream side takes it
	wavhp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.res_valid (res_valid),
		.res       (res),
		.proceed   (proceed),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

>>> hw/rtl/wavhp_in_stage.sv
// ---------------------------------------------------------------------------
// WAV header parser input stage
// Registers one accepted byte and its flags; frees itself whenever the
// parse step can proceed.
// ---------------------------------------------------------------------------
`default_nettype none

module wavhp_in_stage (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_valid,
	output logic                  s_ready,
	input  wavhp_pkg::in_item_t   s_item,
	input  wire                   proceed,
	output logic                  fire,
	output wavhp_pkg::in_item_t   item_s1
);
	import wavhp_pkg::*;

	logic valid_s1;

	assign s_ready = !valid_s1 || proceed;
	assign fire    = valid_s1 && proceed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_ready) begin
			valid_s1 <= s_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_ready && s_valid) begin
			item_s1 <= s_item;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/wavhp_parse.sv
// ---------------------------------------------------------------------------
// WAV header parser state step
// Holds the parse state and advances it by one byte per fire; forms the
// single result of a parse.
// ---------------------------------------------------------------------------
`default_nettype none

module wavhp_parse (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  fire,
	input  wavhp_pkg::in_item_t  item,
	output logic                 res_valid,
	output wavhp_pkg::res_t      res
);
	import wavhp_pkg::*;

	logic [3:0]   phase_q, c_phase, n_phase;
	logic [1:0]   pos_q, c_pos, n_pos;
	logic [31:0]  shift_q, c_shift, n_shift;
	logic [31:0]  skip_q, c_skip, n_skip;
	logic [4:0]   off_q, c_off, n_off;
	logic [127:0] fmt_q, c_fmt, n_fmt;
	logic         fin_q, c_fin, n_fin;
	logic [31:0]  word;
	logic [15:0]  f_tag, f_chan, f_align, f_bits;
	logic [31:0]  f_rate, f_brate;
	logic [1:0]   depth;
	logic         depth_ok;

	// fmt chunk image: byte k of the chunk body sits at bits [8k+7:8k]
	assign f_tag   = c_fmt[15:0];
	assign f_chan  = c_fmt[31:16];
	assign f_rate  = c_fmt[63:32];
	assign f_brate = c_fmt[95:64];
	assign f_align = c_fmt[111:96];
	assign f_bits  = c_fmt[127:112];

	always_comb begin
		depth    = 2'd0;
		depth_ok = 1'b1;
		unique case (f_bits)
			DEPTH_U8:  depth = 2'd0;
			DEPTH_I16: depth = 2'd1;
			DEPTH_F32: depth = 2'd2;
			DEPTH_F64: depth = 2'd3;
			default:   depth_ok = 1'b0;
		endcase
	end

	always_comb begin
		// a first byte restarts from the reset state
		c_phase = item.first_byte ? PH_RIFF : phase_q;
		c_pos   = item.first_byte ? 2'd0 : pos_q;
		c_shift = item.first_byte ? 32'd0 : shift_q;
		c_skip  = item.first_byte ? 32'd0 : skip_q;
		c_off   = item.first_byte ? 5'd0 : off_q;
		c_fmt   = item.first_byte ? 128'd0 : fmt_q;
		c_fin   = item.first_byte ? 1'b0 : fin_q;

		n_phase = c_phase;
		n_pos   = c_pos;
		n_shift = c_shift;
		n_skip  = c_skip;
		n_off   = c_off;
		n_fmt   = c_fmt;
		res_valid = 1'b0;
		res       = '0;
		word      = {item.data_byte, c_shift[31:8]};

		if (!c_fin) begin
			if (c_phase == PH_FMT || c_phase == PH_SKIP) begin
				if (c_phase == PH_FMT && !c_off[4]) begin
					n_fmt[{c_off[3:0], 3'b000} +: 8] = item.data_byte;
					n_off = c_off + 5'd1;
				end
				n_skip = c_skip - 32'd1;
				if (c_skip == 32'd1) begin
					n_phase = PH_ID;
				end
			end else begin
				n_shift = word;
				if (c_pos != 2'd3) begin
					n_pos = c_pos + 2'd1;
				end else begin
					n_pos = 2'd0;
					unique case (c_phase)
						PH_RIFF: begin
							if (word != MAGIC_RIFF) begin
								res_valid  = 1'b1;
								res.status = ST_BAD_RIFF;
							end else begin
								n_phase = PH_RSIZE;
							end
						end
						PH_RSIZE: n_phase = PH_WAVE;
						PH_WAVE: begin
							if (word != MAGIC_WAVE) begin
								res_valid  = 1'b1;
								res.status = ST_BAD_WAVE;
							end else begin
								n_phase = PH_ID;
							end
						end
						PH_ID: begin
							priority if (word == MAGIC_FMT) n_phase = PH_FSIZE;
							else if (word == MAGIC_DATA) n_phase = PH_DSIZE;
							else n_phase = PH_USIZE;
						end
						PH_FSIZE: begin
							n_skip  = word;
							n_off   = 5'd0;
							n_phase = (word != 32'd0) ? PH_FMT : PH_ID;
						end
						PH_USIZE: begin
							n_skip  = word;
							n_phase = (word != 32'd0) ? PH_SKIP : PH_ID;
						end
						PH_DSIZE: begin
							res_valid        = 1'b1;
							res.payload_size = word;
							res.sample_bits  = f_bits;
							res.block_align  = f_align;
							res.byte_rate    = f_brate;
							res.sample_rate  = f_rate;
							res.channels     = f_chan;
							res.format_tag   = f_tag;
							res.not_pcm      = (f_tag != TAG_PCM);
							priority if (!depth_ok) begin
								res.status = ST_BAD_DEPTH;
							end else if (f_chan == CHAN_MONO) begin
								res.status      = ST_OK;
								res.format_code = {depth, 1'b0};
							end else if (f_chan == CHAN_STEREO) begin
								res.status      = ST_OK;
								res.format_code = {depth, 1'b1};
							end else begin
								res.status = ST_BAD_CHAN;
							end
						end
						default: n_phase = PH_RIFF;
					endcase
				end
			end

			// stream ended before a data chunk size was read
			if (!res_valid && item.final_byte) begin
				res_valid  = 1'b1;
				res        = '0;
				res.status = ST_NO_DATA;
			end
		end

		n_fin = c_fin | res_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			pos_q   <= 2'd0;
			shift_q <= 32'd0;
			skip_q  <= 32'd0;
			off_q   <= 5'd0;
			fmt_q   <= 128'd0;
			fin_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= n_phase;
			pos_q   <= n_pos;
			shift_q <= n_shift;
			skip_q  <= n_skip;
			off_q   <= n_off;
			fmt_q   <= n_fmt;
			fin_q   <= n_fin;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/wavhp_out_stage.sv
// ---------------------------------------------------------------------------
// WAV header parser result register
// Holds one result until the downstream side takes it; packs it to tdata.
// ---------------------------------------------------------------------------
`default_nettype none

module wavhp_out_stage (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       fire,
	input  wire                       res_valid,
	input  wavhp_pkg::res_t           res,
	output logic                      proceed,
	output logic                      m_tvalid,
	input  wire                       m_tready,
	output logic [wavhp_pkg::OUT_W-1:0] m_tdata
);
	import wavhp_pkg::*;

	logic valid_q;
	res_t res_q;

	assign proceed  = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {{(OUT_W - $bits(res_t)){1'b0}}, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (proceed) begin
			valid_q <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// WAV header parser core testbench
// Feeds whole and broken RIFF/WAVE byte streams through the slave stream,
// predicts each header or error result with a behavioral parser of its own
// and checks every result transfer field by field, under random idling on
// both sides.
// ---------------------------------------------------------------------------

module testbench;

	import wavhp_pkg::*;

	localparam int IDLE_LIMIT = 1000;   // cycles with no transfer on either side

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'h00;   // [7:0] data_byte
	logic [0:0]   s_tuser = 1'b0;    // [0] first_byte
	logic         s_tlast = 1'b0;    // final_byte
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// [2:0] status, [5:3] format_code, [6] not_pcm, [22:7] format_tag,
	// [38:23] channels, [70:39] sample_rate, [102:71] byte_rate,
	// [118:103] block_align, [134:119] sample_bits, [166:135] payload_size,
	// [167] zero
	logic [167:0] m_tdata;

	wav_header_parser_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Headers still waiting for their result transfer, oldest first
	res_t pending_results[$];
	// Bytes of the file under construction
	logic [7:0] file_bytes[$];

	int bytes_sent;
	int results_expected;
	int results_checked;
	int files_sent;
	int errors;
	int idle_cycles;
	bit tx_calm;   // sender skips its gaps while set
	bit rx_calm;   // receiver keeps tready high while set

	// -----------------------------------------------------------------------
	// Behavioral parser: its own copy of the parse state
	// -----------------------------------------------------------------------
	logic [3:0]   ps_phase;
	logic [1:0]   ps_pos;      // byte lane inside the current 32-bit word
	logic [31:0]  ps_word;     // little-endian shift word
	logic [31:0]  ps_skip;     // bytes left in the chunk being consumed
	logic [4:0]   ps_fofs;     // offset inside the fmt chunk, saturates at 16
	logic [127:0] ps_fmt;      // the 16 captured fmt bytes, byte 0 lowest
	bit           ps_done;     // result given; ignore until a first byte

	function automatic void parse_reset();
		ps_phase = PH_RIFF;
		ps_pos   = 2'd0;
		ps_word  = 32'h0;
		ps_skip  = 32'h0;
		ps_fofs  = 5'd0;
		ps_fmt   = 128'h0;
		ps_done  = 1'b0;
	endfunction

	// Advance the parse by one byte; return 1 when the byte yields a result
	function automatic bit parse_byte(input logic [7:0] b, input bit first, input bit last,
			output res_t r);
		logic [15:0] tag;
		logic [15:0] chan;
		logic [15:0] bits;
		logic [1:0]  depth;
		bit          got;
		r = '0;
		got = 1'b0;
		if (first)
			parse_reset();
		if (ps_done)
			return 1'b0;
		case (ps_phase)
		PH_FMT: begin
			// only the first 16 bytes land in the fields, the rest are skipped
			if (ps_fofs < 5'd16) begin
				ps_fmt[ps_fofs*8 +: 8] = b;
				ps_fofs = ps_fofs + 5'd1;
			end
			ps_skip = ps_skip - 32'd1;
			if (ps_skip == 32'h0)
				ps_phase = PH_ID;
		end
		PH_SKIP: begin
			ps_skip = ps_skip - 32'd1;
			if (ps_skip == 32'h0)
				ps_phase = PH_ID;
		end
		default: begin
			ps_word = {b, ps_word[31:8]};
			if (ps_pos != 2'd3) begin
				ps_pos = ps_pos + 2'd1;
			end else begin
				ps_pos = 2'd0;
				case (ps_phase)
				PH_RIFF: begin
					if (ps_word != MAGIC_RIFF) begin
						r.status = ST_BAD_RIFF;
						got = 1'b1;
					end else begin
						ps_phase = PH_RSIZE;
					end
				end
				PH_RSIZE: ps_phase = PH_WAVE;
				PH_WAVE: begin
					if (ps_word != MAGIC_WAVE) begin
						r.status = ST_BAD_WAVE;
						got = 1'b1;
					end else begin
						ps_phase = PH_ID;
					end
				end
				PH_ID: begin
					if (ps_word == MAGIC_FMT)
						ps_phase = PH_FSIZE;
					else if (ps_word == MAGIC_DATA)
						ps_phase = PH_DSIZE;
					else
						ps_phase = PH_USIZE;
				end
				PH_FSIZE: begin
					ps_skip = ps_word;
					ps_fofs = 5'd0;
					ps_phase = (ps_word != 32'h0) ? PH_FMT : PH_ID;
				end
				PH_USIZE: begin
					ps_skip = ps_word;
					ps_phase = (ps_word != 32'h0) ? PH_SKIP : PH_ID;
				end
				PH_DSIZE: begin
					tag  = ps_fmt[15:0];
					chan = ps_fmt[31:16];
					bits = ps_fmt[127:112];
					depth = 2'd0;
					r.status = ST_OK;
					case (bits)
					DEPTH_U8:  depth = 2'd0;
					DEPTH_I16: depth = 2'd1;
					DEPTH_F32: depth = 2'd2;
					DEPTH_F64: depth = 2'd3;
					default:   r.status = ST_BAD_DEPTH;
					endcase
					if (r.status == ST_OK) begin
						if (chan == CHAN_MONO)
							r.format_code = {depth, 1'b0};
						else if (chan == CHAN_STEREO)
							r.format_code = {depth, 1'b1};
						else
							r.status = ST_BAD_CHAN;
					end
					r.not_pcm      = (tag != TAG_PCM);
					r.format_tag   = tag;
					r.channels     = chan;
					r.sample_rate  = ps_fmt[63:32];
					r.byte_rate    = ps_fmt[95:64];
					r.block_align  = ps_fmt[111:96];
					r.sample_bits  = bits;
					r.payload_size = ps_word;
					got = 1'b1;
				end
				default: ps_phase = PH_RIFF;
				endcase
			end
		end
		endcase
		// a stream that ends without any result reports a missing data chunk
		if (!got && last) begin
			r = '0;
			r.status = ST_NO_DATA;
			got = 1'b1;
		end
		if (got)
			ps_done = 1'b1;
		return got;
	endfunction

	// -----------------------------------------------------------------------
	// Sender side
	// -----------------------------------------------------------------------

	// Offer one byte, wait for its transfer, then predict what it causes
	task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
		int   gap;
		res_t header;
		gap = tx_calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= first;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		if (parse_byte(b, first, last, header)) begin
			pending_results.push_back(header);
			results_expected++;
		end
		bytes_sent++;
	endtask

	// Stream out the built file; noisy adds stray first and final flags
	task automatic send_file(input bit with_first, input bit with_last, input bit noisy);
		int n;
		bit first;
		bit last;
		n = file_bytes.size();
		for (int i = 0; i < n; i++) begin
			first = (with_first && i == 0) || (noisy && $urandom_range(0, 399) == 0);
			last  = (with_last && i == n - 1) || (noisy && $urandom_range(0, 399) == 0);
			send_byte(file_bytes[i], first, last);
		end
		file_bytes.delete();
		files_sent++;
	endtask

	// Hold the sender until every predicted result has been transferred
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic put_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			file_bytes.push_back(w[i*8 +: 8]);
	endtask

	// RIFF magic, random RIFF size, WAVE magic
	task automatic put_head();
		put_word(MAGIC_RIFF);
		put_word($urandom);
		put_word(MAGIC_WAVE);
	endtask

	function automatic logic [127:0] fmt_body(input logic [15:0] tag, input logic [15:0] chan,
			input logic [31:0] rate, input logic [31:0] brate, input logic [15:0] align,
			input logic [15:0] bits);
		return {bits, align, brate, rate, chan, tag};
	endfunction

	// fmt chunk with a given size word; nbytes body bytes follow, random past 16
	task automatic put_fmt(input logic [31:0] size, input logic [127:0] body, input int nbytes);
		put_word(MAGIC_FMT);
		put_word(size);
		for (int i = 0; i < nbytes; i++)
			file_bytes.push_back(i < 16 ? body[i*8 +: 8] : 8'($urandom_range(0, 255)));
	endtask

	task automatic put_chunk(input logic [31:0] id, input logic [31:0] size, input int nbytes);
		put_word(id);
		put_word(size);
		repeat (nbytes) file_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic put_data(input logic [31:0] size);
		put_word(MAGIC_DATA);
		put_word(size);
	endtask

	// Unknown chunk, sometimes with an id one bit away from fmt or data
	task automatic put_unknown();
		logic [31:0] id;
		logic [31:0] size;
		if ($urandom_range(0, 2) == 0)
			id = ($urandom_range(0, 1) ? MAGIC_FMT : MAGIC_DATA) ^ (32'h1 << $urandom_range(0, 31));
		else
			id = $urandom;
		size = ($urandom_range(0, 3) == 0) ? 32'h0 : 32'($urandom_range(1, 24));
		put_chunk(id, size, int'(size));
	endtask

	task automatic put_random_fmt();
		logic [15:0] depths[4];
		logic [31:0] size;
		logic [15:0] bits;
		logic [15:0] chan;
		logic [15:0] tag;
		depths = '{DEPTH_U8, DEPTH_I16, DEPTH_F32, DEPTH_F64};
		case ($urandom_range(0, 5))
		0, 1, 2: size = 32'd16;
		3:       size = 32'd18;
		4:       size = 32'($urandom_range(0, 15));
		default: size = 32'($urandom_range(17, 40));
		endcase
		bits = ($urandom_range(0, 4) != 0) ? depths[$urandom_range(0, 3)] : 16'($urandom);
		chan = ($urandom_range(0, 6) != 0) ? ($urandom_range(0, 1) ? CHAN_STEREO : CHAN_MONO)
			: 16'($urandom);
		tag  = ($urandom_range(0, 3) != 0) ? TAG_PCM : 16'($urandom);
		put_fmt(size, fmt_body(tag, chan, $urandom, $urandom, 16'($urandom), bits), int'(size));
	endtask

	// Well-formed file: header, unknown chunks, usually fmt, data size, a few payload bytes
	task automatic build_random_file();
		put_head();
		repeat ($urandom_range(0, 2)) put_unknown();
		if ($urandom_range(0, 19) != 0)
			put_random_fmt();
		if ($urandom_range(0, 5) == 0) begin
			put_unknown();
			put_random_fmt();
		end
		put_data($urandom);
		repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// -----------------------------------------------------------------------
	// Tests
	// -----------------------------------------------------------------------

	// Right after reset the parser is already armed, no first flag needed
	task automatic test_no_first_flag();
		put_head();
		put_fmt(32'd16, fmt_body(TAG_PCM, CHAN_MONO, 32'd22050, 32'd22050, 16'd1, DEPTH_U8), 16);
		put_data(32'd0);
		send_file(1'b0, 1'b0, 1'b0);
	endtask

	// Every depth and channel pair, field extremes, not-PCM tags
	task automatic test_formats();
		logic [15:0]  depths[4];
		logic [15:0]  tag;
		logic [127:0] body;
		depths = '{DEPTH_U8, DEPTH_I16, DEPTH_F32, DEPTH_F64};
		for (int d = 0; d < 4; d++) begin
			for (int c = 0; c < 2; c++) begin
				tag = (d == 1 && c == 0) ? 16'd3 : (d == 3 && c == 1) ? 16'hFFFF : TAG_PCM;
				body = fmt_body(tag, c ? CHAN_STEREO : CHAN_MONO,
					c ? 32'hFFFF_FFFF : 32'h0, d[0] ? 32'hFFFF_FFFF : 32'h0,
					d[1] ? 16'hFFFF : 16'h0, depths[d]);
				put_head();
				put_fmt(32'd16, body, 16);
				put_data(d == 0 ? 32'h0 : d == 3 ? 32'hFFFF_FFFF : $urandom);
				// a final flag on the byte that completes the header gives no extra result
				send_file(1'b1, c == 1, 1'b0);
			end
		end
	endtask

	// A wrong byte at each lane of both magic words, all-zero and all-ones bytes
	task automatic test_bad_magic();
		for (int k = 0; k < 4; k++) begin
			put_word(MAGIC_RIFF ^ (32'hFF << (8 * k)));
			send_file(1'b1, 1'b0, 1'b0);
		end
		for (int k = 0; k < 4; k++) begin
			put_word(MAGIC_RIFF);
			put_word($urandom);
			put_word(MAGIC_WAVE ^ (32'h80 << (8 * k)));
			// bytes after the result, final one included, are dropped
			repeat (3) file_bytes.push_back(8'($urandom_range(0, 255)));
			send_file(1'b1, 1'b1, 1'b0);
		end
		put_word(32'h0);
		send_file(1'b1, 1'b0, 1'b0);
		put_word(32'hFFFF_FFFF);
		send_file(1'b1, 1'b0, 1'b0);
	endtask

	// Unsupported depth, unsupported channel count, no fmt chunk at all
	task automatic test_header_errors();
		logic [15:0] odd_vals[3];
		odd_vals = '{16'd0, 16'd24, 16'hFFFF};
		for (int k = 0; k < 3; k++) begin
			put_head();
			put_fmt(32'd16, fmt_body(TAG_PCM, CHAN_MONO, $urandom, $urandom, 16'd2, odd_vals[k]), 16);
			put_data($urandom);
			send_file(1'b1, 1'b0, 1'b0);
		end
		odd_vals = '{16'd0, 16'd3, 16'hFFFF};
		for (int k = 0; k < 3; k++) begin
			put_head();
			put_fmt(32'd16, fmt_body(TAG_PCM, odd_vals[k], $urandom, $urandom, 16'd4, DEPTH_I16),
				16);
			put_data($urandom);
			send_file(1'b1, 1'b0, 1'b0);
		end
		put_head();
		put_chunk($urandom, 32'd5, 5);
		put_data(32'd100);
		send_file(1'b1, 1'b0, 1'b0);
	endtask

	// Long, short, repeated, empty and odd-sized chunks
	task automatic test_fmt_lengths();
		// long fmt chunk: bytes past the sixteenth are skipped
		put_head();
		put_fmt(32'd40, fmt_body(TAG_PCM, CHAN_STEREO, 32'd48000, 32'd192000, 16'd4, DEPTH_I16),
			40);
		put_data(32'd1024);
		send_file(1'b1, 1'b0, 1'b0);
		// a later, shorter fmt chunk overwrites all but the sample bits
		put_head();
		put_fmt(32'd16, fmt_body(TAG_PCM, CHAN_STEREO, 32'd8000, 32'd32000, 16'd4, DEPTH_F32),
			16);
		put_fmt(32'd14, fmt_body(16'd3, CHAN_MONO, 32'd96000, 32'd768000, 16'd8, DEPTH_U8), 14);
		put_data($urandom);
		send_file(1'b1, 1'b0, 1'b0);
		// empty fmt, empty unknown and odd-sized unknown chunks, no pad byte
		put_head();
		put_fmt(32'd0, 128'h0, 0);
		put_chunk($urandom, 32'd0, 0);
		put_chunk($urandom, 32'd3, 3);
		put_fmt(32'd16, fmt_body(TAG_PCM, CHAN_MONO, 32'd11025, 32'd88200, 16'd8, DEPTH_F64), 16);
		put_data($urandom);
		send_file(1'b1, 1'b0, 1'b0);
		// one-byte fmt chunk fills the low lane of the tag only
		put_head();
		put_fmt(32'd1, fmt_body(16'hABCD, CHAN_MONO, 32'h0, 32'h0, 16'h0, DEPTH_U8), 1);
		put_data($urandom);
		send_file(1'b1, 1'b0, 1'b0);
	endtask

	// End of stream at awkward places, restart in mid-parse, a full drain
	task automatic test_stream_end();
		logic [127:0] body;
		body = fmt_body(TAG_PCM, CHAN_STEREO, 32'd44100, 32'd176400, 16'd4, DEPTH_I16);
		// final byte halfway through the RIFF word
		put_word(MAGIC_RIFF);
		void'(file_bytes.pop_back());
		void'(file_bytes.pop_back());
		send_file(1'b1, 1'b1, 1'b0);
		// a single byte that both starts and ends the stream
		file_bytes.push_back(8'($urandom_range(0, 255)));
		send_file(1'b1, 1'b1, 1'b0);
		// end inside the fmt fields
		put_head();
		put_fmt(32'd16, body, 7);
		send_file(1'b1, 1'b1, 1'b0);
		// end inside an unknown chunk of maximum size
		put_head();
		put_chunk($urandom, 32'hFFFF_FFFF, 6);
		send_file(1'b1, 1'b1, 1'b0);
		// maximum-size fmt chunk cut short after its fields
		put_head();
		put_fmt(32'hFFFF_FFFF, body, 20);
		send_file(1'b1, 1'b1, 1'b0);
		// abandoned file, then a first flag restarts on a complete one
		put_head();
		put_chunk($urandom, 32'd10, 4);
		send_file(1'b1, 1'b0, 1'b0);
		put_head();
		put_fmt(32'd16, body, 16);
		put_data(32'd4096);
		send_file(1'b1, 1'b0, 1'b0);
		wait_for_results();
	endtask

	// Mostly well-formed files with random content, plus cut, corrupt and noise streams
	task automatic test_random();
		int kind;
		int cut;
		int pos;
		while ((bytes_sent < 1800 || results_expected < 80) && bytes_sent < 20000) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 99);
			build_random_file();
			if (kind >= 65 && kind < 80) begin
				cut = $urandom_range(1, file_bytes.size() - 1);
				while (file_bytes.size() > cut)
					void'(file_bytes.pop_back());
			end else if (kind >= 80 && kind < 90) begin
				pos = $urandom_range(0, 3) + ($urandom_range(0, 1) ? 8 : 0);
				file_bytes[pos] = file_bytes[pos] ^ 8'($urandom_range(1, 255));
			end else if (kind >= 90) begin
				file_bytes.delete();
				repeat ($urandom_range(1, 40)) file_bytes.push_back(8'($urandom_range(0, 255)));
			end
			send_file($urandom_range(0, 19) != 0,
				(kind < 65) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 1) == 1), 1'b1);
			if (files_sent % 12 == 0)
				wait_for_results();
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// -----------------------------------------------------------------------
	// Receiver side: random stall per result, or tready held high while calm
	// -----------------------------------------------------------------------
	initial begin
		@(posedge arst_n);
		forever begin
			if (!rx_calm) begin
				m_tready <= 1'b0;
				do @(posedge clk); while (!m_tvalid);
				repeat ($urandom_range(0, 19)) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// -----------------------------------------------------------------------
	// Result checking
	// -----------------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (seen !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
			errors++;
		end
	endtask

	res_t seen_res;
	res_t want_res;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_res = m_tdata[166:0];
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing pending: status %0d", seen_res.status);
				errors++;
			end else begin
				want_res = pending_results.pop_front();
				check_field("status", 32'(want_res.status), 32'(seen_res.status));
				check_field("format_code", 32'(want_res.format_code),
					32'(seen_res.format_code));
				check_field("not_pcm", 32'(want_res.not_pcm), 32'(seen_res.not_pcm));
				check_field("format_tag", 32'(want_res.format_tag), 32'(seen_res.format_tag));
				check_field("channels", 32'(want_res.channels), 32'(seen_res.channels));
				check_field("sample_rate", want_res.sample_rate, seen_res.sample_rate);
				check_field("byte_rate", want_res.byte_rate, seen_res.byte_rate);
				check_field("block_align", 32'(want_res.block_align),
					32'(seen_res.block_align));
				check_field("sample_bits", 32'(want_res.sample_bits),
					32'(seen_res.sample_bits));
				check_field("payload_size", want_res.payload_size, seen_res.payload_size);
				check_field("pad", 32'h0, 32'(m_tdata[167]));
			end
			results_checked++;
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Sequence
	// -----------------------------------------------------------------------
	initial begin
		// the parser comes out of reset armed, so the model starts the same way
		parse_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_no_first_flag();
		test_formats();
		test_bad_magic();
		test_header_errors();
		test_fmt_lengths();
		test_stream_end();
		test_random();
		// drain, then leave room for any stray result after the last one
		wait_for_results();
		repeat (10) @(posedge clk);
		$display("Parsed %0d streams, %0d bytes; %0d results compared.",
			files_sent, bytes_sent, results_checked);
		$display("Covered all formats, magic and header errors, chunk sizes, stream ends.");
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/wavhp_pkg.sv
hw/rtl/wavhp_in_stage.sv
hw/rtl/wavhp_parse.sv
hw/rtl/wavhp_out_stage.sv
hw/rtl/wav_header_parser_core.sv
bench/testbench.sv
